// ===== rtl/core/kji_pkg.sv =====
// Shared types, register codes, reset values and saturation helper for the joint interpolator.
`default_nettype none

package kji_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_FPS    = 4'd0;
    localparam logic [3:0] REG_OFFSET = 4'd1;
    localparam logic [3:0] REG_FRAMES = 4'd2;
    localparam logic [3:0] REG_JOINTS = 4'd3;

    // Request opcodes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register reset values.
    localparam logic [15:0] FPS_RESET    = 16'd12800;
    localparam logic [15:0] OFFSET_RESET = 16'd0;
    localparam logic [10:0] FRAMES_RESET = 11'd2;
    localparam logic [5:0]  JOINTS_RESET = 6'd1;

    localparam logic signed [51:0] SAT_HIGH = 52'sd2147483647;
    localparam logic signed [51:0] SAT_LOW  = -52'sd2147483648;

    // Bookkeeping that travels with one joint through the datapath.
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [4:0]  joint;
        logic [15:0] blend;
        logic        top;
        logic        mid;
    } kji_tag_t;

    // Saturates a wide signed value to 32 bits.
    function automatic logic signed [31:0] clip32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > SAT_HIGH)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_LOW)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/keyframe_joint_interpolator_unit.sv =====
// Top level of the keyframe joint interpolator: registers, sequencer and store.
`default_nettype none

// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_ready   opcode, frame_number, joint_number,
//                                                position_value, query_time
// result    out        result_valid/result_ready joint_index, blended_position,
//                                                blended_velocity, last_joint
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load request writes the store at the edge it is accepted. A query request
// passes through the frame unit stages (scale, offset, clamp, neighbor selection),
// then takes two read slots per joint: each joint needs three frames of the store
// and the store has two read ports. Reset clears the registers and the sequencer;
// the store is not cleared and must be loaded before it is queried. A low
// result_ready while result_valid is high freezes the read ports and the blend
// datapath; item_ready is high only while the sequencer is idle.

module keyframe_joint_interpolator_unit #(
    parameter int MAX_FRAMES = 1024,
    parameter int MAX_JOINTS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               opcode,
    input  logic [9:0]         frame_number,
    input  logic [4:0]         joint_number,
    input  logic signed [31:0] position_value,
    input  logic [31:0]        query_time,
    output logic               result_valid,
    input  logic               result_ready,
    output logic [4:0]         joint_index,
    output logic signed [31:0] blended_position,
    output logic signed [31:0] blended_velocity,
    output logic               last_joint,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    import kji_pkg::*;

    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int JOINT_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int ADDR_W  = FRAME_W + JOINT_W;
    localparam int DEPTH   = MAX_FRAMES * (2 ** JOINT_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_PH0,
        ST_PH1
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;
    logic [1:0]         setup_cnt_reg;
    logic [1:0]         setup_cnt_next;
    logic [JOINT_W-1:0] joint_reg;
    logic [JOINT_W-1:0] joint_next;

    // Configuration registers.
    logic [15:0] fps_reg;
    logic [15:0] offset_reg;
    logic [10:0] frame_count_reg;
    logic [5:0]  joint_count_reg;

    logic               adv;
    logic               item_take;
    logic               load_write;
    logic               query_start;
    logic [JOINT_W-1:0] last_joint_num;
    logic               final_joint;

    logic [FRAME_W-1:0] base_frame;
    logic [FRAME_W-1:0] next_frame;
    logic [FRAME_W-1:0] far_frame;
    logic [15:0]        blend;
    logic               top_flag;
    logic               mid_flag;

    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic [ADDR_W-1:0]  wr_addr;
    logic [31:0]        rd_data_a;
    logic [31:0]        rd_data_b;
    kji_tag_t           issue_tag;

    // The datapath moves whenever the output register is empty or being drained.
    assign adv        = !result_valid || result_ready;
    assign item_ready = (state_reg == ST_IDLE);
    assign item_take  = item_valid && item_ready;

    // A load outside the store size set by MAX_FRAMES and MAX_JOINTS is dropped.
    assign load_write = item_take && (opcode == OP_LOAD)
                        && (32'(frame_number) < 32'(MAX_FRAMES))
                        && (32'(joint_number) < 32'(MAX_JOINTS));
    assign query_start = item_take && (opcode == OP_QUERY);
    assign wr_addr     = {FRAME_W'(frame_number), JOINT_W'(joint_number)};

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg         <= FPS_RESET;
            offset_reg      <= OFFSET_RESET;
            frame_count_reg <= FRAMES_RESET;
            joint_count_reg <= JOINTS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FPS:    fps_reg         <= cfg_data;
                REG_OFFSET: offset_reg      <= cfg_data;
                REG_FRAMES: frame_count_reg <= cfg_data[10:0];
                REG_JOINTS: joint_count_reg <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    // Index of the final joint, with the joint count held to its legal range.
    always_comb
    begin
        if (joint_count_reg == 6'd0)
        begin
            last_joint_num = '0;
        end
        else if (32'(joint_count_reg) > 32'(MAX_JOINTS))
        begin
            last_joint_num = JOINT_W'(MAX_JOINTS - 1);
        end
        else
        begin
            last_joint_num = JOINT_W'(joint_count_reg - 6'd1);
        end
    end

    assign final_joint = (joint_reg == last_joint_num);

    // Sequencer: wait for the frame unit, then issue two read slots per joint.
    // The first slot reads the base and next frames, the second the frame after next where one exists.
    always_comb
    begin
        state_next     = state_reg;
        setup_cnt_next = setup_cnt_reg;
        joint_next     = joint_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_start)
                begin
                    state_next     = ST_SETUP;
                    setup_cnt_next = '0;
                    joint_next     = '0;
                end
            end
            ST_SETUP:
            begin
                setup_cnt_next = setup_cnt_reg + 2'd1;
                if (setup_cnt_reg == 2'd3)
                begin
                    state_next = ST_PH0;
                end
            end
            ST_PH0:
            begin
                if (adv)
                begin
                    state_next = ST_PH1;
                end
            end
            ST_PH1:
            begin
                if (adv)
                begin
                    if (final_joint)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PH0;
                        joint_next = joint_reg + JOINT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            setup_cnt_reg <= '0;
            joint_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            setup_cnt_reg <= setup_cnt_next;
            joint_reg     <= joint_next;
        end
    end

    assign rd_addr_a = (state_reg == ST_PH1) ? {far_frame, joint_reg} : {base_frame, joint_reg};
    assign rd_addr_b = {next_frame, joint_reg};

    always_comb
    begin
        issue_tag.valid = (state_reg == ST_PH0);
        issue_tag.last  = final_joint;
        issue_tag.joint = 5'(joint_reg);
        issue_tag.blend = blend;
        issue_tag.top   = top_flag;
        issue_tag.mid   = mid_flag;
    end

    kji_frame #(
        .MAX_FRAMES (MAX_FRAMES),
        .FRAME_W    (FRAME_W)
    ) u_frame (
        .clk               (clk),
        .rst_n             (rst_n),
        .load_time         (query_start),
        .query_time        (query_time),
        .frames_per_second (fps_reg),
        .offset_frames     (offset_reg),
        .frame_count       (frame_count_reg),
        .base_frame        (base_frame),
        .next_frame        (next_frame),
        .far_frame         (far_frame),
        .blend             (blend),
        .top_flag          (top_flag),
        .mid_flag          (mid_flag)
    );

    kji_store #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .clk       (clk),
        .rd_en     (adv),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .wr_en     (load_write),
        .wr_addr   (wr_addr),
        .wr_data   (position_value)
    );

    kji_blend u_blend (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (adv),
        .issue_tag         (issue_tag),
        .rd_data_a         (rd_data_a),
        .rd_data_b         (rd_data_b),
        .frames_per_second (fps_reg),
        .result_valid      (result_valid),
        .joint_index       (joint_index),
        .blended_position  (blended_position),
        .blended_velocity  (blended_velocity),
        .last_joint        (last_joint)
    );

    // A query always starts its joint sweep at joint zero.
    a_setup_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |-> (joint_reg == '0))
        else $error("joint counter not cleared during query setup");

    // The second read slot of the final joint ends the sweep.
    a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PH1 && adv && final_joint) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the final joint");

endmodule

`default_nettype wire

// ===== rtl/core/kji_store.sv =====
// Position store: one write port and two registered read ports.
`default_nettype none

module kji_store #(
    parameter int ADDR_W = 15,
    parameter int DEPTH  = 32768
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [31:0]       rd_data_a,
    output logic [31:0]       rd_data_b,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data
);

    logic [31:0] store_mem [0:DEPTH-1];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[rd_addr_a];
            rd_b_reg <= store_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

`default_nettype wire

// ===== rtl/core/kji_frame.sv =====
// Time to frame conversion: scale, offset, clamp and neighbor frame selection.
`default_nettype none

module kji_frame #(
    parameter int MAX_FRAMES = 1024,
    parameter int FRAME_W    = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_time,
    input  logic [31:0]        query_time,
    input  logic [15:0]        frames_per_second,
    input  logic [15:0]        offset_frames,
    input  logic [10:0]        frame_count,
    output logic [FRAME_W-1:0] base_frame,
    output logic [FRAME_W-1:0] next_frame,
    output logic [FRAME_W-1:0] far_frame,
    output logic [15:0]        blend,
    output logic               top_flag,
    output logic               mid_flag
);

    logic [31:0]         time_reg;
    logic [47:0]         prod_reg;
    logic [39:0]         fsub_reg;
    logic [FRAME_W+15:0] fclamp_reg;
    logic [FRAME_W-1:0]  base_reg;
    logic [FRAME_W-1:0]  next_reg;
    logic [FRAME_W-1:0]  far_reg;
    logic [15:0]         blend_reg;
    logic                top_reg;
    logic                mid_reg;

    logic [FRAME_W-1:0]  last_frame;
    logic [39:0]         scaled;
    logic [39:0]         offset_q;
    logic [FRAME_W+15:0] top_q;
    logic [FRAME_W-1:0]  i0;
    logic [FRAME_W-1:0]  base_v;
    logic                mid_v;

    // Last usable frame index, with the frame count held to its legal range.
    always_comb
    begin
        if (frame_count < 11'd2)
        begin
            last_frame = FRAME_W'(1);
        end
        else if (32'(frame_count) > 32'(MAX_FRAMES))
        begin
            last_frame = FRAME_W'(MAX_FRAMES - 1);
        end
        else
        begin
            last_frame = FRAME_W'(frame_count - 11'd1);
        end
    end

    assign scaled   = prod_reg[47:8];
    assign offset_q = 40'({offset_frames, 16'h0000});
    assign top_q    = {last_frame, 16'h0000};
    assign i0       = fclamp_reg[FRAME_W+15:16];
    assign base_v   = (i0 < last_frame) ? i0 : last_frame - FRAME_W'(1);
    assign mid_v    = i0 < (last_frame - FRAME_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg   <= '0;
            prod_reg   <= '0;
            fsub_reg   <= '0;
            fclamp_reg <= '0;
            base_reg   <= '0;
            next_reg   <= '0;
            far_reg    <= '0;
            blend_reg  <= '0;
            top_reg    <= 1'b0;
            mid_reg    <= 1'b0;
        end
        else
        begin
            if (load_time)
            begin
                time_reg <= query_time;
            end
            prod_reg   <= time_reg * frames_per_second;
            fsub_reg   <= (scaled > offset_q) ? scaled - offset_q : '0;
            fclamp_reg <= (fsub_reg > 40'(top_q)) ? top_q : (FRAME_W+16)'(fsub_reg);
            base_reg   <= base_v;
            next_reg   <= base_v + FRAME_W'(1);
            far_reg    <= mid_v ? base_v + FRAME_W'(2) : base_v + FRAME_W'(1);
            blend_reg  <= fclamp_reg[15:0];
            top_reg    <= (i0 == last_frame);
            mid_reg    <= mid_v;
        end
    end

    assign base_frame = base_reg;
    assign next_frame = next_reg;
    assign far_frame  = far_reg;
    assign blend      = blend_reg;
    assign top_flag   = top_reg;
    assign mid_flag   = mid_reg;

    // A time clamped to the last frame never also has a third frame after it.
    a_top_not_mid: assert property (@(posedge clk) disable iff (!rst_n)
        !(top_reg && mid_reg))
        else $error("frame unit flags last frame and middle frame at once");

endmodule

`default_nettype wire

// ===== rtl/core/kji_blend.sv =====
// Per-joint datapath: frame differences, velocity scaling, blending and saturation.
`default_nettype none

module kji_blend (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  kji_pkg::kji_tag_t   issue_tag,
    input  logic [31:0]         rd_data_a,
    input  logic [31:0]         rd_data_b,
    input  logic [15:0]         frames_per_second,
    output logic                result_valid,
    output logic [4:0]          joint_index,
    output logic signed [31:0]  blended_position,
    output logic signed [31:0]  blended_velocity,
    output logic                last_joint
);

    import kji_pkg::*;

    kji_tag_t tag_r_reg;
    kji_tag_t tag_h_reg;
    kji_tag_t tag_a_reg;
    kji_tag_t tag_b_reg;
    kji_tag_t tag_c_reg;
    kji_tag_t tag_d_reg;
    kji_tag_t tag_e_reg;
    logic     out_valid_reg;

    logic signed [31:0] p0_h_reg;
    logic signed [31:0] p1_h_reg;
    logic signed [31:0] base_a_reg;
    logic signed [32:0] dp_a_reg;
    logic signed [32:0] d01_a_reg;
    logic signed [32:0] d12_a_reg;
    logic signed [31:0] base_b_reg;
    logic signed [49:0] mp_b_reg;
    logic signed [49:0] m01_b_reg;
    logic signed [49:0] m12_b_reg;
    logic signed [31:0] pos_c_reg;
    logic signed [31:0] va_c_reg;
    logic signed [31:0] vb_c_reg;
    logic signed [31:0] pos_d_reg;
    logic signed [31:0] va_d_reg;
    logic signed [32:0] dv_d_reg;
    logic signed [31:0] pos_e_reg;
    logic signed [31:0] va_e_reg;
    logic signed [49:0] mv_e_reg;
    logic signed [31:0] pos_out_reg;
    logic signed [31:0] vel_out_reg;
    logic [4:0]         joint_out_reg;
    logic               last_out_reg;

    logic signed [31:0] p2_now;
    logic signed [31:0] base_sel;
    logic signed [16:0] fps_s;
    logic signed [49:0] mp_w;
    logic signed [49:0] m01_w;
    logic signed [49:0] m12_w;
    logic signed [49:0] mv_w;
    logic signed [31:0] pos_w;
    logic signed [31:0] va_w;
    logic signed [31:0] vb_w;
    logic signed [31:0] vel_w;

    assign p2_now   = $signed(rd_data_a);
    assign base_sel = tag_h_reg.top ? p1_h_reg : p0_h_reg;
    assign fps_s    = $signed({1'b0, frames_per_second});

    assign mp_w  = dp_a_reg * $signed({1'b0, tag_a_reg.blend});
    assign m01_w = d01_a_reg * fps_s;
    assign m12_w = d12_a_reg * fps_s;

    assign pos_w = clip32(((52'(base_b_reg) <<< 16) + 52'(mp_b_reg) + 52'sd32768) >>> 16);
    assign va_w  = clip32((52'(m01_b_reg) + 52'sd128) >>> 8);
    assign vb_w  = tag_b_reg.mid ? clip32((52'(m12_b_reg) + 52'sd128) >>> 8) : va_w;

    assign mv_w  = dv_d_reg * $signed({1'b0, tag_d_reg.blend});
    assign vel_w = clip32(((52'(va_e_reg) <<< 16) + 52'(mv_e_reg) + 52'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_r_reg     <= '0;
            tag_h_reg     <= '0;
            tag_a_reg     <= '0;
            tag_b_reg     <= '0;
            tag_c_reg     <= '0;
            tag_d_reg     <= '0;
            tag_e_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_r_reg     <= issue_tag;
            tag_h_reg     <= tag_r_reg;
            tag_a_reg     <= tag_h_reg;
            tag_b_reg     <= tag_a_reg;
            tag_c_reg     <= tag_b_reg;
            tag_d_reg     <= tag_c_reg;
            tag_e_reg     <= tag_d_reg;
            out_valid_reg <= tag_e_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (tag_r_reg.valid)
            begin
                p0_h_reg <= $signed(rd_data_a);
                p1_h_reg <= $signed(rd_data_b);
            end
            base_a_reg    <= base_sel;
            dp_a_reg      <= 33'(p1_h_reg) - 33'(base_sel);
            d01_a_reg     <= 33'(p1_h_reg) - 33'(p0_h_reg);
            d12_a_reg     <= 33'(p2_now) - 33'(p1_h_reg);
            base_b_reg    <= base_a_reg;
            mp_b_reg      <= mp_w;
            m01_b_reg     <= m01_w;
            m12_b_reg     <= m12_w;
            pos_c_reg     <= pos_w;
            va_c_reg      <= va_w;
            vb_c_reg      <= vb_w;
            pos_d_reg     <= pos_c_reg;
            va_d_reg      <= va_c_reg;
            dv_d_reg      <= 33'(vb_c_reg) - 33'(va_c_reg);
            pos_e_reg     <= pos_d_reg;
            va_e_reg      <= va_d_reg;
            mv_e_reg      <= mv_w;
            pos_out_reg   <= pos_e_reg;
            vel_out_reg   <= vel_w;
            joint_out_reg <= tag_e_reg.joint;
            last_out_reg  <= tag_e_reg.last;
        end
    end

    assign result_valid     = out_valid_reg;
    assign joint_index      = joint_out_reg;
    assign blended_position = pos_out_reg;
    assign blended_velocity = vel_out_reg;
    assign last_joint       = last_out_reg;

    // The two frame reads of one joint arrive in consecutive slots, so the
    // hold stage and the read stage never carry a first read at the same time.
    a_read_slots: assert property (@(posedge clk) disable iff (!rst_n)
        tag_h_reg.valid |-> !tag_r_reg.valid)
        else $error("overlapping first read slots in the blend datapath");

endmodule

`default_nettype wire

// ===== verif/tb_keyframe_joint_interpolator_unit.sv =====
// Self-checking testbench for the keyframe joint interpolator: directed and random requests.
`timescale 1ns / 1ps

module tb_keyframe_joint_interpolator_unit;
    import kji_pkg::*;

    localparam int FRAME_SLOTS      = 1024;
    localparam int JOINT_SLOTS      = 32;
    // Cycles without any handshake before the run is declared hung. The longest quiet
    // stretch of a correct run is the long receiver hold plus one query of 32 joints.
    localparam int STALL_LIMIT      = 3000;
    // Cycles allowed after the last expected result for a load still in flight.
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 300;

    // One request as the sender offers it.
    typedef struct {
        logic               opcode;
        logic [9:0]         frame;
        logic [4:0]         joint;
        logic signed [31:0] position;
        logic [31:0]        query_at;
    } request_t;

    // One joint result as the interpolator should return it.
    typedef struct {
        logic [4:0]         joint;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               last;
    } joint_result_t;

    // Every input starts at a known value; reset is held low from time zero.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    logic               opcode = OP_LOAD;
    logic [9:0]         frame_number = '0;
    logic [4:0]         joint_number = '0;
    logic signed [31:0] position_value = '0;
    logic [31:0]        query_time = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    logic [4:0]         joint_index;
    logic signed [31:0] blended_position;
    logic signed [31:0] blended_velocity;
    logic               last_joint;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = REG_FPS;
    logic [15:0]        cfg_data = '0;

    // Register settings as the interpolator holds them, updated at each accepted write.
    int fps_setting    = int'(FPS_RESET);
    int offset_setting = int'(OFFSET_RESET);
    int frames_setting = int'(FRAMES_RESET);
    int joints_setting = int'(JOINTS_RESET);

    // Position store as seen by accepted loads, and the entries the stimulus has queued a load for.
    logic signed [31:0] joint_store [FRAME_SLOTS][JOINT_SLOTS];
    bit                 entry_loaded [FRAME_SLOTS][JOINT_SLOTS];

    request_t      request_queue[$];
    joint_result_t expected_joints[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int loads_seen     = 0;
    int queries_seen   = 0;
    int results_seen   = 0;
    int settings_used  = 1;

    // Idle control. The stimulus raises no_idle for the last phase and bumps
    // long_hold_asks when it wants the receiver to hold off for a long stretch.
    bit no_idle        = 1'b0;
    int long_hold_asks = 0;
    int long_hold_seen = 0;
    int send_gap       = 0;
    int send_steady    = 0;
    int take_stall     = 0;
    int take_steady    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    keyframe_joint_interpolator_unit #(
        .MAX_FRAMES(FRAME_SLOTS),
        .MAX_JOINTS(JOINT_SLOTS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .opcode          (opcode),
        .frame_number    (frame_number),
        .joint_number    (joint_number),
        .position_value  (position_value),
        .query_time      (query_time),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .joint_index     (joint_index),
        .blended_position(blended_position),
        .blended_velocity(blended_velocity),
        .last_joint      (last_joint),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Interpolation predictor
    // ------------------------------------------------------------------

    // Frame and joint counts as the block uses them: out-of-range settings are
    // pulled back to the nearest legal value.
    function automatic int frames_in_use();
        int n;
        n = frames_setting;
        if (n < 2)
            n = 2;
        if (n > FRAME_SLOTS)
            n = FRAME_SLOTS;
        return n;
    endfunction

    function automatic int joints_in_use();
        int n;
        n = joints_setting;
        if (n < 1)
            n = 1;
        if (n > JOINT_SLOTS)
            n = JOINT_SLOTS;
        return n;
    endfunction

    // Turns a query time into the lower frame and the 16-bit blend toward the next
    // frame. The scaled time is a Q.16 frame number, shifted back by the offset and
    // clamped to the frames in use.
    function automatic void locate_frame(input logic [31:0] at, output int base,
                                         output int blend);
        longint pos;
        longint off;
        longint top;
        pos = (longint'(at) * longint'(fps_setting)) >>> 8;
        off = longint'(offset_setting) <<< 16;
        pos = (pos > off) ? pos - off : 64'sd0;
        top = longint'(frames_in_use() - 1) <<< 16;
        if (pos > top)
            pos = top;
        base = int'(pos >>> 16);
        blend = int'(pos & 64'hFFFF);
    endfunction

    function automatic logic signed [31:0] saturate_word(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Rounded linear mix of two Q16.16 values with a 16-bit weight on the second.
    function automatic logic signed [31:0] mix_pair(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input int w);
        longint s;
        s = longint'(a) * longint'(65536 - w) + longint'(b) * longint'(w) + 64'sd32768;
        return saturate_word(s >>> 16);
    endfunction

    // Forward difference to the next frame, scaled to units per second. The last
    // frame has no successor and takes the slope of the frame before it.
    function automatic logic signed [31:0] frame_slope(input int frame, input int joint);
        int     f;
        longint diff;
        f = frame;
        if (f + 1 >= frames_in_use())
            f = frames_in_use() - 2;
        diff = longint'(joint_store[f + 1][joint]) - longint'(joint_store[f][joint]);
        return saturate_word((diff * longint'(fps_setting) + 64'sd128) >>> 8);
    endfunction

    // Expected results of one accepted query: one per joint in use, in joint order.
    task automatic predict_query(input logic [31:0] at);
        int            base;
        int            blend;
        int            upper;
        int            nj;
        joint_result_t r;
        locate_frame(at, base, blend);
        upper = (base + 1 < frames_in_use()) ? base + 1 : frames_in_use() - 1;
        nj = joints_in_use();
        for (int j = 0; j < nj; j++)
        begin
            r.joint = 5'(j);
            r.position = mix_pair(joint_store[base][j], joint_store[upper][j], blend);
            r.velocity = mix_pair(frame_slope(base, j), frame_slope(upper, j), blend);
            r.last = (j + 1 == nj);
            expected_joints.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Compares the result on the outputs with the oldest expected joint result.
    task automatic check_result();
        joint_result_t want;
        if (expected_joints.size() == 0)
        begin
            report_mismatch($sformatf("result for joint %0d with none expected", joint_index));
            return;
        end
        want = expected_joints.pop_front();
        results_seen++;
        if (joint_index !== want.joint)
            report_mismatch($sformatf("joint_index %0d, expected %0d",
                                      joint_index, want.joint));
        if (blended_position !== want.position)
            report_mismatch($sformatf("joint %0d position %h, expected %h",
                                      want.joint, blended_position, want.position));
        if (blended_velocity !== want.velocity)
            report_mismatch($sformatf("joint %0d velocity %h, expected %h",
                                      want.joint, blended_velocity, want.velocity));
        if (last_joint !== want.last)
            report_mismatch($sformatf("joint %0d last_joint %b, expected %b",
                                      want.joint, last_joint, want.last));
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Offers queued requests. An offered request holds its payload until accepted.
    // Between requests the sender idles in random bursts, except during steady
    // stretches and in the final phase. Each accepted request updates the predictor.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t rq;
        bit       busy;
        bit       offer;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_gap = 0;
            send_steady = 0;
        end
        else
        begin
            busy = item_valid && !item_ready;
            offer = busy;
            if (item_valid && item_ready)
            begin
                if (opcode == OP_LOAD)
                begin
                    joint_store[frame_number][joint_number] = position_value;
                    loads_seen++;
                end
                else
                begin
                    predict_query(query_time);
                    queries_seen++;
                end
                accepted_count++;
            end
            if (send_steady > 0)
                send_steady--;
            else if ($urandom_range(0, 29) == 0)
                send_steady = $urandom_range(20, 60);
            if (!busy)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (!no_idle && send_steady == 0 && $urandom_range(0, 4) == 0)
                begin
                    // The sender idles in this cycle and starts an idle burst.
                    send_gap = $urandom_range(0, 6);
                end
                else if (request_queue.size() > 0)
                begin
                    rq = request_queue.pop_front();
                    opcode <= rq.opcode;
                    frame_number <= rq.frame;
                    joint_number <= rq.joint;
                    position_value <= rq.position;
                    query_time <= rq.query_at;
                    offer = 1'b1;
                end
            end
            item_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    // Takes results and checks them. Ready drops in short random bursts, and once,
    // on request of the stimulus, for a long hold that backs the block up.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        bit take;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            take_stall = 0;
            take_steady = 0;
            hold_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (take_steady > 0)
                take_steady--;
            else if ($urandom_range(0, 29) == 0)
                take_steady = $urandom_range(20, 60);
            take = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (long_hold_asks != long_hold_seen)
            begin
                long_hold_seen = long_hold_asks;
                hold_left = LONG_HOLD_CYCLES - 1;
            end
            else if (take_stall > 0)
            begin
                take_stall--;
            end
            else if (!no_idle && take_steady == 0 && $urandom_range(0, 3) == 0)
            begin
                take_stall = $urandom_range(0, 6);
            end
            else
            begin
                take = 1'b1;
            end
            result_ready <= take;
        end
    end

    // Ends the run if no channel completes a handshake for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_joints.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic signed [31:0] pick_position();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
            default: return $signed($urandom);
        endcase
    endfunction

    // Query times: the extremes, raw random words (which mostly clamp to the last
    // frame), and times aimed at a random point across the offset and stored frames.
    function automatic logic [31:0] pick_query_time();
        longint target;
        longint at;
        int     span;
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            2, 3:    return $urandom;
            default: ;
        endcase
        if (fps_setting == 0)
            return $urandom;
        span = frames_in_use() - 1 + offset_setting;
        target = (longint'($urandom_range(0, span)) <<< 16) +
                 longint'($urandom_range(0, 65535));
        at = (target <<< 8) / longint'(fps_setting);
        if (at > 64'sh0FFFFFFFF)
            at = 64'sh0FFFFFFFF;
        return at[31:0];
    endfunction

    task automatic add_load(input int frame, input int joint,
                            input logic signed [31:0] value);
        request_t rq;
        rq.opcode = OP_LOAD;
        rq.frame = 10'(frame);
        rq.joint = 5'(joint);
        rq.position = value;
        rq.query_at = $urandom;
        request_queue.push_back(rq);
        entry_loaded[frame][joint] = 1'b1;
        queued_count++;
    endtask

    // Queues a query, first loading any store entry it would read that was never
    // written. A query reads at most three neighboring frames for each joint.
    task automatic add_query(input logic [31:0] at);
        request_t rq;
        int       base;
        int       blend;
        int       lo;
        int       hi;
        locate_frame(at, base, blend);
        lo = (base < frames_in_use() - 2) ? base : frames_in_use() - 2;
        hi = (base + 2 < frames_in_use()) ? base + 2 : frames_in_use() - 1;
        for (int f = lo; f <= hi; f++)
        begin
            for (int j = 0; j < joints_in_use(); j++)
            begin
                if (!entry_loaded[f][j])
                    add_load(f, j, pick_position());
            end
        end
        rq.opcode = OP_QUERY;
        rq.frame = 10'($urandom);
        rq.joint = 5'($urandom);
        rq.position = $signed($urandom);
        rq.query_at = at;
        request_queue.push_back(rq);
        queued_count++;
    endtask

    // Mostly queries; the rest are loads to random entries anywhere in the store.
    task automatic add_random_items(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 65)
                add_query(pick_query_time());
            else
                add_load($urandom_range(0, FRAME_SLOTS - 1), $urandom_range(0, JOINT_SLOTS - 1),
                         pick_position());
        end
    endtask

    // Waits until every queued request is accepted and every expected result has
    // been checked, then lets a trailing load finish before anything else happens.
    task automatic wait_until_drained();
        while (accepted_count != queued_count || expected_joints.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [3:0] index, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= 16'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (index)
            REG_FPS:    fps_setting = value & 16'hFFFF;
            REG_OFFSET: offset_setting = value & 16'hFFFF;
            REG_FRAMES: frames_setting = value & 11'h7FF;
            REG_JOINTS: joints_setting = value & 6'h3F;
            default:    ;
        endcase
    endtask

    // Writes all four registers; only called while the block is idle.
    task automatic apply_setting(input int fps, input int offset, input int frames,
                                 input int joints);
        write_register(REG_FPS, fps);
        write_register(REG_OFFSET, offset);
        write_register(REG_FRAMES, frames);
        write_register(REG_JOINTS, joints);
        settings_used++;
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed requests under the reset settings (50 frames per second, two
        // frames, one joint). Frame 0 holds the largest position and frame 1 the
        // smallest, so the slope saturates negative.
        add_load(0, 0, 32'sh7FFFFFFF);
        add_load(1, 0, 32'sh80000000);
        add_query(32'h0);
        add_query(32'hFFFFFFFF);
        // 656 / 65536 s at 50 frames per second is just past half a frame.
        add_query(32'h00000290);
        // A load at the far corner of the store and patterned values in the middle.
        add_load(1023, 31, 32'sh00000000);
        add_load(512, 16, 32'sh12345678);
        add_load(341, 10, 32'shA5A5A5A5);
        add_load(682, 21, 32'sh5A5A5A5A);
        // A gentle ramp from -1.0 to +1.0, queried at the start, a quarter and the end.
        add_load(0, 0, 32'shFFFF0000);
        add_load(1, 0, 32'sh00010000);
        add_query(32'h0);
        add_query(32'h00000148);
        add_query(32'h00008000);
        wait_until_drained();

        // Highest frame rate with every joint. The receiver holds off for a long
        // stretch while the queries keep coming, so the block backs up.
        apply_setting(65535, 0, 8, 32);
        add_random_items(45);
        long_hold_asks++;
        wait_until_drained();

        // Lowest frame rate behind the largest offset: every query lands on frame 0.
        apply_setting(1, 65535, 1024, 4);
        add_random_items(30);
        wait_until_drained();

        // Zero frame rate: frame 0 only and no motion.
        apply_setting(0, 3, 16, 8);
        add_random_items(30);
        wait_until_drained();

        // Frame and joint counts below their minimum act as two frames and one joint.
        apply_setting(7680, 2, 0, 0);
        add_random_items(30);
        wait_until_drained();

        // Counts above their maximum act as the full store; few requests, since each
        // query may need almost a hundred loads first.
        apply_setting(12800, 0, 2047, 63);
        add_random_items(12);
        wait_until_drained();

        // Random mid-range settings. The first one pauses the sender halfway until
        // every result is back.
        apply_setting($urandom_range(256, 16384), $urandom_range(0, 4),
                      $urandom_range(2, 64), $urandom_range(1, 32));
        add_random_items(20);
        wait_until_drained();
        add_random_items(20);
        wait_until_drained();

        apply_setting($urandom_range(256, 16384), $urandom_range(0, 4),
                      $urandom_range(2, 64), $urandom_range(1, 32));
        add_random_items(40);
        wait_until_drained();

        // Final phase at full rate on both sides.
        no_idle <= 1'b1;
        apply_setting(25600, 1, 5, 3);
        add_random_items(30);
        wait_until_drained();

        if (expected_joints.size() != 0)
            report_mismatch($sformatf("%0d joint results never arrived",
                                      expected_joints.size()));
        $display("Run covered %0d loads and %0d queries over %0d register settings.",
                 loads_seen, queries_seen, settings_used);
        $display("Checked %0d joint results and found %0d mismatches.",
                 results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
